// ===== sv/lge_pkg.sv =====
// Shared constants for the life generation engine: command codes,
// field widths and the B3/S23 neighbor counts.
// No dependencies; imported by every module of the block.
package lge_pkg;

    // Field widths of the stream beats and the registers
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 6;
    localparam int BITS_W = 64;
    localparam int CFG_W  = 7;

    // Command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Register select (paddr[2])
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Reset value of both size registers
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // B3/S23 neighbor counts
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

endpackage

// ===== sv/lge_cell_lane.sv =====
// One cell lane: counts the eight neighbors of a cell and applies B3/S23.
// Depends on lge_pkg.
module lge_cell_lane
    import lge_pkg::*;
(
    input  logic [2:0] up_bits,     // column c-1, c, c+1 of the row above
    input  logic [1:0] side_bits,   // column c-1, c+1 of the same row
    input  logic [2:0] down_bits,   // column c-1, c, c+1 of the row below
    input  logic       center_bit,
    output logic       next_bit
);

    logic [3:0] nbr_count;

    // Neighbor population count
    assign nbr_count = 4'(up_bits[0]) + 4'(up_bits[1]) + 4'(up_bits[2])
                     + 4'(side_bits[0]) + 4'(side_bits[1])
                     + 4'(down_bits[0]) + 4'(down_bits[1]) + 4'(down_bits[2]);

    // Birth on three, survive on two
    assign next_bit = (nbr_count == NBR_BIRTH) || ((nbr_count == NBR_KEEP) && center_bit);

endmodule

// ===== sv/lge_row_merge.sv =====
// Row of cell lanes plus the merge stage that keeps border columns.
// Depends on lge_pkg and lge_cell_lane.
module lge_row_merge
    import lge_pkg::*;
#(
    parameter int BOARD_WIDTH = 64
) (
    input  logic [BOARD_WIDTH-1:0] row_above,
    input  logic [BOARD_WIDTH-1:0] row_here,
    input  logic [BOARD_WIDTH-1:0] row_below,
    input  logic [CFG_W-1:0]       ncols,
    output logic [BOARD_WIDTH-1:0] row_next
);

    logic [BOARD_WIDTH+1:0] pad_above;
    logic [BOARD_WIDTH+1:0] pad_here;
    logic [BOARD_WIDTH+1:0] pad_below;
    logic [BOARD_WIDTH-1:0] lane_out;
    logic [BOARD_WIDTH-1:0] interior;

    // Dead cells just outside the word on both sides
    assign pad_above = {1'b0, row_above, 1'b0};
    assign pad_here  = {1'b0, row_here,  1'b0};
    assign pad_below = {1'b0, row_below, 1'b0};

    for (genvar c = 0; c < BOARD_WIDTH; c++) begin : g_lane
        lge_cell_lane u_lane (
            .up_bits    (pad_above[c+2:c]),
            .side_bits  ({pad_here[c+2], pad_here[c]}),
            .down_bits  (pad_below[c+2:c]),
            .center_bit (row_here[c]),
            .next_bit   (lane_out[c])
        );
        // Column c is updated only between the border columns
        assign interior[c] = (c >= 1) && ((32'(c) + 32'd1) < 32'(ncols));
    end

    // Merge: lanes inside, old cells on the borders and beyond
    assign row_next = (lane_out & interior) | (row_here & ~interior);

endmodule

// ===== sv/life_generation_engine_top.sv =====
// Life generation engine: row-organized cell board with write, read and
// B3/S23 step commands. Write, unknown command and a step on a board under
// 3x3 answer in the cycle after the beat is accepted; a read passes through
// S_READ; a step sweeps the rows in use (capped at BOARD_HEIGHT), one board read per row.
// One command is in flight at a time. Reset: a clearing pass zeroes the
// board with s_tready low; sizes reset to 64.
module life_generation_engine_top
    import lge_pkg::*;
#(
    parameter int BOARD_WIDTH  = 64,
    parameter int BOARD_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [5:0] row_index, [69:6] row_bits, [71:70] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] read_bits
    output logic [1:0]  m_tuser,   // [1:0] done_cmd
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = (BOARD_HEIGHT > 1) ? $clog2(BOARD_HEIGHT) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_STEP} state_t;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [CFG_W-1:0]       cols_reg;
    logic [CFG_W-1:0]       rows_reg;
    logic                   m_tvalid_reg;
    logic [BITS_W-1:0]      m_tdata_reg;
    logic [CMD_W-1:0]       m_tuser_reg;
    logic                   rd_ok_reg;
    logic [CFG_W-1:0]       rd_cnt_reg;
    logic [CFG_W-1:0]       rd_row_reg;
    logic                   rd_vld_reg;
    logic [BOARD_WIDTH-1:0] above_reg;
    logic [BOARD_WIDTH-1:0] here_reg;
    logic [BOARD_WIDTH-1:0] rdata_reg;

    logic [BOARD_WIDTH-1:0] board_mem [BOARD_HEIGHT];

    logic [CMD_W-1:0]       s_cmd;
    logic [IDX_W-1:0]       s_row_index;
    logic [BITS_W-1:0]      s_row_bits;
    logic                   s_accept;
    logic                   idx_in_range;
    logic [ADDR_W-1:0]      idx_addr;
    logic [CFG_W-1:0]       ncols;
    logic [CFG_W-1:0]       nrows;
    logic                   degenerate;
    logic                   issue;
    logic                   wb_valid;
    logic                   cfg_write;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [BOARD_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [BOARD_WIDTH-1:0] row_next;

    // Unpack the command beat
    assign s_cmd       = s_tuser;
    assign s_row_index = s_tdata[IDX_W-1:0];
    assign s_row_bits  = s_tdata[IDX_W+BITS_W-1:IDX_W];

    assign s_tready     = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept     = s_tvalid && s_tready;
    assign idx_in_range = 32'(s_row_index) < BOARD_HEIGHT;
    assign idx_addr     = ADDR_W'(s_row_index);

    // Sizes saturated to the board
    assign ncols = (32'(cols_reg) > BOARD_WIDTH)  ? CFG_W'(BOARD_WIDTH)  : cols_reg;
    assign nrows = (32'(rows_reg) > BOARD_HEIGHT) ? CFG_W'(BOARD_HEIGHT) : rows_reg;
    assign degenerate = (ncols < 7'd3) || (nrows < 7'd3);

    // Step sweep: one row read issued per cycle, writeback two rows behind
    assign issue    = (state_reg == S_STEP) && (rd_cnt_reg < nrows);
    assign wb_valid = (state_reg == S_STEP) && rd_vld_reg && (rd_row_reg >= 7'd2);

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);

    // Memory port muxing
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = BOARD_WIDTH'(s_row_bits);
        mem_raddr = idx_addr;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (wb_valid) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(rd_row_reg - 7'd1);
            mem_wdata = row_next;
        end else if (s_accept && (s_cmd == CMD_WRITE) && idx_in_range) begin
            mem_we = 1'b1;
        end
        if (state_reg == S_STEP) begin
            mem_raddr = ADDR_W'(rd_cnt_reg);
        end
    end

    // Board memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            board_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= board_mem[mem_raddr];
    end

    // Old-generation row window
    always_ff @(posedge aclk) begin
        if ((state_reg == S_STEP) && rd_vld_reg) begin
            above_reg <= here_reg;
            here_reg  <= rdata_reg;
        end
    end

    // Lanes and merge for the row being rewritten
    lge_row_merge #(
        .BOARD_WIDTH (BOARD_WIDTH)
    ) u_merge (
        .row_above (above_reg),
        .row_here  (here_reg),
        .row_below (rdata_reg),
        .ncols     (ncols),
        .row_next  (row_next)
    );

    // Control state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            cols_reg     <= CFG_RESET;
            rows_reg     <= CFG_RESET;
            m_tvalid_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (paddr[2] == REG_ROWS) begin
                    rows_reg <= pwdata[CFG_W-1:0];
                end else begin
                    cols_reg <= pwdata[CFG_W-1:0];
                end
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(BOARD_HEIGHT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        rd_ok_reg <= idx_in_range;
                        if (s_cmd == CMD_READ) begin
                            state_reg <= S_READ;
                        end else if ((s_cmd == CMD_STEP) && !degenerate) begin
                            state_reg  <= S_STEP;
                            rd_cnt_reg <= '0;
                            rd_vld_reg <= 1'b0;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= s_cmd;
                        end
                    end
                end
                S_READ: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= rd_ok_reg ? BITS_W'(rdata_reg) : '0;
                    m_tuser_reg  <= CMD_READ;
                    state_reg    <= S_IDLE;
                end
                S_STEP: begin
                    rd_vld_reg <= issue;
                    rd_row_reg <= rd_cnt_reg;
                    if (issue) begin
                        rd_cnt_reg <= rd_cnt_reg + 7'd1;
                    end
                    // Last row's data arrived: border row, sweep done
                    if (rd_vld_reg && (rd_row_reg == nrows - 7'd1)) begin
                        rd_vld_reg   <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= CMD_STEP;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Only a read beat carries row data
    a_data_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != CMD_READ)) |-> (m_tdata == '0))
        else $error("non-read result carries nonzero data");

    // Step writeback stays on interior rows
    a_wb_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_valid |-> ((rd_row_reg >= 7'd2) && (rd_row_reg < nrows)))
        else $error("step writeback outside interior rows");

    // Sweep counter never passes the row count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |-> (rd_cnt_reg <= nrows))
        else $error("step read counter overran");

    // A new command never lands on an undrained result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("pending result overwritten");

endmodule
